>>> src/gdc_pkg.sv
// Shared types, tables and helper functions for the Gregorian date checker.
`timescale 1ns / 1ps

package gdc_pkg;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // Month offsets for the weekday sum; index is the month number, unused codes give zero.
    localparam logic [2:0] MONTH_OFFSET [16] = '{
        3'd0, 3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6,
        3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd0, 3'd0, 3'd0
    };

    // Stage one: characters checked and turned into two-digit numbers.
    typedef struct packed {
        logic       digits_ok;
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] year_hi;
        logic [6:0] year_lo;
    } gdc_parsed_t;

    // Stage two: flags settled, previous year split into centuries and years.
    typedef struct packed {
        logic       digit_err;
        logic       zero_err;
        logic       range_err;
        logic [2:0] month_adj;
        logic [4:0] day_m1;
        logic [6:0] prev_hi;
        logic [6:0] prev_lo;
    } gdc_checked_t;

    // Stage three: weekday sum before the reduction mod 7.
    typedef struct packed {
        logic       digit_err;
        logic       zero_err;
        logic       range_err;
        logic [9:0] sum;
    } gdc_summed_t;

    // Final result word.
    typedef struct packed {
        logic [2:0] weekday;
        logic       digit_error;
        logic       zero_error;
        logic       range_error;
        logic       valid_res;
    } gdc_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    // Value of two decimal characters; only meaningful when both are digits.
    function automatic logic [6:0] dec_pair(input logic [7:0] tens, input logic [7:0] units);
        dec_pair = ({3'b000, tens[3:0]} * 7'd10) + {3'b000, units[3:0]};
    endfunction

endpackage

>>> src/gdc_in_if.sv
// Input channel carrying one date word as eight ASCII characters.
`timescale 1ns / 1ps

interface gdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] day_tens_char;
    logic [7:0] day_units_char;
    logic [7:0] month_tens_char;
    logic [7:0] month_units_char;
    logic [7:0] year_thousands_char;
    logic [7:0] year_hundreds_char;
    logic [7:0] year_tens_char;
    logic [7:0] year_units_char;

    modport source (
        output valid, day_tens_char, day_units_char, month_tens_char, month_units_char,
               year_thousands_char, year_hundreds_char, year_tens_char, year_units_char,
        input  ready
    );
    modport sink (
        input  valid, day_tens_char, day_units_char, month_tens_char, month_units_char,
               year_thousands_char, year_hundreds_char, year_tens_char, year_units_char,
        output ready
    );
endinterface

>>> src/gdc_out_if.sv
// Output channel carrying one result word: weekday and error flags.
`timescale 1ns / 1ps

interface gdc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] weekday;
    logic       digit_error;
    logic       zero_error;
    logic       range_error;
    logic       valid_res;

    modport source (
        output valid, weekday, digit_error, zero_error, range_error, valid_res,
        input  ready
    );
    modport sink (
        input  valid, weekday, digit_error, zero_error, range_error, valid_res,
        output ready
    );
endinterface

>>> src/gdc_parse.sv
// First pipeline stage: character check and two-digit number forming.
`timescale 1ns / 1ps

module gdc_parse
    import gdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   chars [8],
    output logic         out_valid,
    input  logic         out_ready,
    output gdc_parsed_t  out_data
);

    logic        valid_reg;
    gdc_parsed_t data_reg;
    gdc_parsed_t data_next;
    logic [7:0]  digit_flags;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digit_flags[i] = is_digit(chars[i]);
        end
        data_next.digits_ok = &digit_flags;
        data_next.day       = dec_pair(chars[0], chars[1]);
        data_next.month     = dec_pair(chars[2], chars[3]);
        data_next.year_hi   = dec_pair(chars[4], chars[5]);
        data_next.year_lo   = dec_pair(chars[6], chars[7]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/gdc_check.sv
// Second pipeline stage: error flags, leap rule and previous-year split.
`timescale 1ns / 1ps

module gdc_check
    import gdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  gdc_parsed_t  in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output gdc_checked_t out_data
);

    logic         valid_reg;
    gdc_checked_t data_reg;
    gdc_checked_t data_next;
    logic         leap;
    logic         bad_range;
    logic         short_month;

    always_comb
    begin
        // The year is year_hi * 100 + year_lo, so the leap rule needs no division.
        leap = (in_data.year_lo[1:0] == 2'b00)
            && ((in_data.year_lo != 7'd0) || (in_data.year_hi[1:0] == 2'b00));

        short_month = (in_data.month == 7'd4) || (in_data.month == 7'd6)
                   || (in_data.month == 7'd9) || (in_data.month == 7'd11);

        if ((in_data.month > 7'd12) || (in_data.day > 7'd31))
        begin
            bad_range = 1'b1;
        end
        else if ((in_data.day > 7'd30) && short_month)
        begin
            bad_range = 1'b1;
        end
        else if (in_data.month == 7'd2)
        begin
            bad_range = in_data.day > (leap ? 7'd29 : 7'd28);
        end
        else
        begin
            bad_range = 1'b0;
        end

        data_next.digit_err = !in_data.digits_ok;
        data_next.zero_err  = in_data.digits_ok
            && ((in_data.day == 7'd0) || (in_data.month == 7'd0)
                || ((in_data.year_hi == 7'd0) && (in_data.year_lo == 7'd0)));
        data_next.range_err = in_data.digits_ok && bad_range;

        data_next.month_adj = MONTH_OFFSET[in_data.month[3:0]]
            + {2'b00, (leap && (in_data.month > 7'd2))};
        data_next.day_m1    = in_data.day[4:0] - 5'd1;

        // Previous year, split into hundreds and the remainder below one hundred.
        if (in_data.year_lo == 7'd0)
        begin
            data_next.prev_hi = in_data.year_hi - 7'd1;
            data_next.prev_lo = 7'd99;
        end
        else
        begin
            data_next.prev_hi = in_data.year_hi;
            data_next.prev_lo = in_data.year_lo - 7'd1;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/gdc_weekday.sv
// Third and fourth pipeline stages: weekday sum, reduction mod 7 and result register.
`timescale 1ns / 1ps

module gdc_weekday
    import gdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  gdc_checked_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output gdc_result_t  out_data
);

    logic        sum_valid_reg;
    gdc_summed_t sum_reg;
    gdc_summed_t sum_next;
    logic        sum_ready;

    logic        res_valid_reg;
    gdc_result_t res_reg;
    gdc_result_t res_next;

    logic [4:0]  fold_a;
    logic [3:0]  fold_b;
    logic [2:0]  residue;
    logic        date_ok;

    // With p = 100*hi + lo, the sum p%7 + p/4 - p/100 + p/400 is congruent
    // to 5*hi + lo + lo/4 + hi/4 modulo 7.
    always_comb
    begin
        sum_next.digit_err = in_data.digit_err;
        sum_next.zero_err  = in_data.zero_err;
        sum_next.range_err = in_data.range_err;
        sum_next.sum = ({3'b000, in_data.prev_hi} * 10'd5)
                     + {3'b000, in_data.prev_lo}
                     + {5'b00000, in_data.prev_lo[6:2]}
                     + {5'b00000, in_data.prev_hi[6:2]}
                     + {7'b0000000, in_data.month_adj}
                     + {5'b00000, in_data.day_m1};
    end

    // Eight is one modulo 7, so octal digits are added twice and one subtract finishes.
    always_comb
    begin
        fold_a  = {2'b00, sum_reg.sum[2:0]} + {2'b00, sum_reg.sum[5:3]}
                + {2'b00, sum_reg.sum[8:6]} + {4'b0000, sum_reg.sum[9]};
        fold_b  = {1'b0, fold_a[2:0]} + {2'b00, fold_a[4:3]};
        residue = (fold_b >= 4'd7) ? 3'(fold_b - 4'd7) : fold_b[2:0];
        date_ok = !sum_reg.digit_err && !sum_reg.zero_err && !sum_reg.range_err;

        res_next.weekday     = date_ok ? residue : 3'd0;
        res_next.digit_error = sum_reg.digit_err;
        res_next.zero_error  = sum_reg.zero_err;
        res_next.range_error = sum_reg.range_err;
        res_next.valid_res   = date_ok;
    end

    assign sum_ready = !res_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                res_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sum_reg <= sum_next;
        end
        if (sum_ready && sum_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

>>> src/gregorian_date_check_day_of_week.sv
// Top level of the Gregorian date checker and day-of-week pipeline.
`timescale 1ns / 1ps

// This block takes a date word of eight ASCII characters (day, month, four-digit
// year) and returns one result word per date: the weekday from Monday 0 to
// Sunday 6 on the proleptic Gregorian calendar, plus flags for a non-digit
// character, a zero day, month or year, and a day or month out of range. When
// any flag is set, valid_res is low and the weekday reads 0. The zero and range
// flags are only raised when all eight characters are digits, and both may be
// set together. The datapath is a four-stage pipeline: character check and
// two-digit forming, error flags and leap rule, weekday sum, and the reduction
// mod 7 into the result register. A new word is taken every cycle while the
// output does not stall. Each stage holds its own valid bit and accepts a word
// whenever it is empty or its word moves on, so a stall on the output fills
// bubbles before it stops the input. The block holds no state besides the
// pipeline and needs no initialization after reset.

module gregorian_date_check_day_of_week
    import gdc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    gdc_in_if.sink          date_in,
    gdc_out_if.source       result_out
);

    logic [7:0]   chars [8];

    logic         parse_valid;
    logic         parse_ready;
    gdc_parsed_t  parse_data;

    logic         check_valid;
    logic         check_ready;
    gdc_checked_t check_data;

    gdc_result_t  result;

    // Character order follows the written date: day, month, then year from the top digit.
    assign chars[0] = date_in.day_tens_char;
    assign chars[1] = date_in.day_units_char;
    assign chars[2] = date_in.month_tens_char;
    assign chars[3] = date_in.month_units_char;
    assign chars[4] = date_in.year_thousands_char;
    assign chars[5] = date_in.year_hundreds_char;
    assign chars[6] = date_in.year_tens_char;
    assign chars[7] = date_in.year_units_char;

    gdc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (date_in.valid),
        .in_ready  (date_in.ready),
        .chars     (chars),
        .out_valid (parse_valid),
        .out_ready (parse_ready),
        .out_data  (parse_data)
    );

    gdc_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (parse_valid),
        .in_ready  (parse_ready),
        .in_data   (parse_data),
        .out_valid (check_valid),
        .out_ready (check_ready),
        .out_data  (check_data)
    );

    // The last stage is the output register, so nothing combinational reaches the result port.
    gdc_weekday u_weekday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (check_valid),
        .in_ready  (check_ready),
        .in_data   (check_data),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (result)
    );

    assign result_out.weekday     = result.weekday;
    assign result_out.digit_error = result.digit_error;
    assign result_out.zero_error  = result.zero_error;
    assign result_out.range_error = result.range_error;
    assign result_out.valid_res   = result.valid_res;

endmodule

>>> src/gdc_checker.sv
// Port-level checks on the date checker, attached to the top level by bind.
`timescale 1ns / 1ps

module gdc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] weekday,
    input logic       digit_error,
    input logic       zero_error,
    input logic       range_error,
    input logic       valid_res
);

    // A word is good exactly when no error flag is raised.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_res == !(digit_error || zero_error || range_error)))
        else $error("valid_res disagrees with the error flags");

    // A rejected date always reports Monday.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (weekday == 3'd0))
        else $error("weekday not cleared on an invalid date");

    // Numbers are only checked when every character is a digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && digit_error) |-> (!zero_error && !range_error))
        else $error("zero or range flag raised on non-digit input");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (weekday != 3'd7))
        else $error("weekday out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(weekday) && $stable(valid_res)
            && $stable(digit_error) && $stable(zero_error) && $stable(range_error)))
        else $error("stalled result word changed");

endmodule

bind gregorian_date_check_day_of_week gdc_checker u_gdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .weekday     (result_out.weekday),
    .digit_error (result_out.digit_error),
    .zero_error  (result_out.zero_error),
    .range_error (result_out.range_error),
    .valid_res   (result_out.valid_res)
);

>>> verif/tb_gregorian_date_check_day_of_week.sv
// Self-checking testbench for the Gregorian date checker with random flow control.
`timescale 1ns / 1ps

// The bench sends date words into the checker from a table of directed cases,
// then from a long random phase. The expected result of each accepted word,
// from its table entry or a local model of the calendar rules, is queued.
// Each result word leaving the block is checked field by field against the
// oldest queued result. Both the sender and the receiver hold off for a
// random number of cycles per word. In some stretches neither side holds off,
// so the pipeline sees full rate as well as bubbles and back pressure.

module tb_gregorian_date_check_day_of_week;
    import gdc_pkg::*;

    localparam int NUM_RANDOM     = 700;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    // One date word as eight characters; the first field is the most significant
    // byte, so an eight-character string literal maps onto it directly.
    typedef struct packed {
        logic [7:0] day_tens;
        logic [7:0] day_units;
        logic [7:0] month_tens;
        logic [7:0] month_units;
        logic [7:0] year_thousands;
        logic [7:0] year_hundreds;
        logic [7:0] year_tens;
        logic [7:0] year_units;
    } date_word_t;

    // A directed case. When typed is set, want holds the expected result word;
    // otherwise the local calendar model supplies it.
    typedef struct packed {
        logic [63:0] chars;
        logic        typed;
        gdc_result_t want;
    } date_case_t;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam gdc_result_t RES_NONE = '0;
    localparam gdc_result_t RES_MONDAY =
        '{weekday: 3'd0, digit_error: 1'b0, zero_error: 1'b0, range_error: 1'b0, valid_res: 1'b1};
    localparam gdc_result_t RES_DIGIT =
        '{weekday: 3'd0, digit_error: 1'b1, zero_error: 1'b0, range_error: 1'b0, valid_res: 1'b0};
    localparam gdc_result_t RES_ZERO =
        '{weekday: 3'd0, digit_error: 1'b0, zero_error: 1'b1, range_error: 1'b0, valid_res: 1'b0};
    localparam gdc_result_t RES_RANGE =
        '{weekday: 3'd0, digit_error: 1'b0, zero_error: 1'b0, range_error: 1'b1, valid_res: 1'b0};
    localparam gdc_result_t RES_ZERO_RANGE =
        '{weekday: 3'd0, digit_error: 1'b0, zero_error: 1'b1, range_error: 1'b1, valid_res: 1'b0};

    // Weekday shift of the first of each month in a common year, indexed by month.
    localparam int MONTH_SHIFT [13] = '{0, 0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    localparam int NUM_DIRECTED = 25;
    localparam date_case_t DIRECTED_CASES [NUM_DIRECTED] = '{
        // Earliest date: year one starts on a Monday.
        '{"01010001", 1'b1, RES_MONDAY},
        // Zero day, month, year, and all zeros.
        '{"00012000", 1'b1, RES_ZERO},
        '{"01002000", 1'b1, RES_ZERO},
        '{"01010000", 1'b1, RES_ZERO},
        '{"00000000", 1'b1, RES_ZERO},
        // Zero and range flags raised together.
        '{"00132000", 1'b1, RES_ZERO_RANGE},
        '{"32002000", 1'b1, RES_ZERO_RANGE},
        // Out of range day or month.
        '{"32012000", 1'b1, RES_RANGE},
        '{"31042021", 1'b1, RES_RANGE},
        '{"29021900", 1'b1, RES_RANGE},
        '{"29022023", 1'b1, RES_RANGE},
        '{"99999999", 1'b1, RES_RANGE},
        // Characters just outside the digit range, and the byte extremes.
        '{"/1012000", 1'b1, RES_DIGIT},
        '{"0101200:", 1'b1, RES_DIGIT},
        '{"00:02000", 1'b1, RES_DIGIT},
        '{64'h0000_0000_0000_0000, 1'b1, RES_DIGIT},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, RES_DIGIT},
        // Valid dates around the leap rule and the calendar extremes.
        '{"31129999", 1'b0, RES_NONE},
        '{"30042021", 1'b0, RES_NONE},
        '{"29022000", 1'b0, RES_NONE},
        '{"29022024", 1'b0, RES_NONE},
        '{"28022023", 1'b0, RES_NONE},
        '{"01032024", 1'b0, RES_NONE},
        '{"15101582", 1'b0, RES_NONE},
        '{"31121999", 1'b0, RES_NONE}
    };

    logic clk;
    logic rst_n;

    gdc_in_if  date_in ();
    gdc_out_if result_out ();

    gregorian_date_check_day_of_week u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .date_in    (date_in),
        .result_out (result_out)
    );

    gdc_result_t pending_results [$];
    int          error_count;
    int          idle_cycles;
    // When set, neither side inserts idle cycles, so words flow back to back.
    bit          full_rate;

    // Calendar model: flags first, then the weekday for a valid date.
    function automatic gdc_result_t predict_result(input date_word_t w);
        logic [7:0]  chars [8];
        bit          all_digits;
        bit          leap;
        int          dd;
        int          mm;
        int          yy;
        int          prev;
        int          month_len;
        int          sum;
        gdc_result_t r;
        chars = '{w.day_tens, w.day_units, w.month_tens, w.month_units,
                  w.year_thousands, w.year_hundreds, w.year_tens, w.year_units};
        all_digits = 1'b1;
        foreach (chars[i])
        begin
            if (chars[i] < CHAR_ZERO || chars[i] > CHAR_NINE)
                all_digits = 1'b0;
        end
        r = '0;
        r.digit_error = !all_digits;
        if (all_digits)
        begin
            dd = int'(w.day_tens - CHAR_ZERO) * 10 + int'(w.day_units - CHAR_ZERO);
            mm = int'(w.month_tens - CHAR_ZERO) * 10 + int'(w.month_units - CHAR_ZERO);
            yy = int'(w.year_thousands - CHAR_ZERO) * 1000
               + int'(w.year_hundreds - CHAR_ZERO) * 100
               + int'(w.year_tens - CHAR_ZERO) * 10 + int'(w.year_units - CHAR_ZERO);
            leap = (yy % 4 == 0) && ((yy % 100 != 0) || (yy % 400 == 0));
            case (mm)
                4, 6, 9, 11: month_len = 30;
                2:           month_len = leap ? 29 : 28;
                default:     month_len = 31;
            endcase
            r.zero_error  = (dd == 0) || (mm == 0) || (yy == 0);
            r.range_error = (mm > 12) || (dd > month_len);
            if (!r.zero_error && !r.range_error)
            begin
                prev = yy - 1;
                sum  = MONTH_SHIFT[mm] + ((leap && mm > 2) ? 1 : 0)
                     + prev % 7 + prev / 4 - prev / 100 + prev / 400 + dd - 1;
                r.weekday   = 3'(sum % 7);
                r.valid_res = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic date_word_t digits_of(input int dd, input int mm, input int yy);
        date_word_t w;
        w.day_tens       = CHAR_ZERO + 8'(dd / 10);
        w.day_units      = CHAR_ZERO + 8'(dd % 10);
        w.month_tens     = CHAR_ZERO + 8'(mm / 10);
        w.month_units    = CHAR_ZERO + 8'(mm % 10);
        w.year_thousands = CHAR_ZERO + 8'(yy / 1000);
        w.year_hundreds  = CHAR_ZERO + 8'((yy / 100) % 10);
        w.year_tens      = CHAR_ZERO + 8'((yy / 10) % 10);
        w.year_units     = CHAR_ZERO + 8'(yy % 10);
        return w;
    endfunction

    // Random date word. Most are real calendar dates, with extra weight on the
    // end of February in century years; the rest are digit strings with
    // numbers near the limits, words with one damaged character, and noise.
    function automatic date_word_t random_date();
        int          kind;
        int          dd;
        int          mm;
        int          yy;
        int          month_len;
        int          pos;
        logic [63:0] bits;
        kind = $urandom_range(0, 99);
        if (kind < 78)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                yy = $urandom_range(1, 99) * 100;
                mm = 2;
                dd = $urandom_range(28, 29);
            end
            else
            begin
                yy = $urandom_range(1, 9999);
                mm = $urandom_range(1, 12);
                case (mm)
                    4, 6, 9, 11: month_len = 30;
                    2:           month_len = 29;
                    default:     month_len = 31;
                endcase
                dd = $urandom_range(1, month_len);
            end
            bits = digits_of(dd, mm, yy);
            // Damage one character of some well-formed dates.
            if (kind >= 68)
            begin
                pos = $urandom_range(0, 7);
                bits[pos * 8 +: 8] = 8'($urandom_range(0, 255));
            end
        end
        else if (kind < 92)
        begin
            dd   = $urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(0, 33);
            mm   = $urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(0, 13);
            yy   = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : $urandom_range(0, 9999);
            bits = digits_of(dd, mm, yy);
        end
        else
        begin
            bits = {$urandom, $urandom};
        end
        return date_word_t'(bits);
    endfunction

    // Offer one date word, after a random hold-off, and queue its result at
    // the edge where the checker takes it. When the hold-off is zero, valid
    // stays high from the previous word and only the payload changes.
    task automatic send_date(input date_word_t w, input bit typed, input gdc_result_t want);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            date_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        date_in.valid               <= 1'b1;
        date_in.day_tens_char       <= w.day_tens;
        date_in.day_units_char      <= w.day_units;
        date_in.month_tens_char     <= w.month_tens;
        date_in.month_units_char    <= w.month_units;
        date_in.year_thousands_char <= w.year_thousands;
        date_in.year_hundreds_char  <= w.year_hundreds;
        date_in.year_tens_char      <= w.year_tens;
        date_in.year_units_char     <= w.year_units;
        @(posedge clk);
        while (!date_in.ready)
            @(posedge clk);
        pending_results.push_back(typed ? want : predict_result(w));
    endtask

    // Stop sending and let the pipeline empty before going on.
    task automatic drain_results();
        date_in.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver holds ready low for a random number of cycles before each
    // result word, then keeps it high until a word is taken.
    initial
    begin : result_sink
        int stall;
        result_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = full_rate ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                result_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_out.ready <= 1'b1;
            @(posedge clk);
            while (!result_out.valid)
                @(posedge clk);
        end
    end

    // Every result word taken by the receiver is matched against the oldest
    // expected result.
    always @(posedge clk)
    begin
        gdc_result_t want;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result word, expected none, actual %b %b %b %b %0d",
                         $time, result_out.valid_res, result_out.digit_error,
                         result_out.zero_error, result_out.range_error, result_out.weekday);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("weekday", 32'(want.weekday), 32'(result_out.weekday));
                check_field("digit_error", 32'(want.digit_error),
                            32'(result_out.digit_error));
                check_field("zero_error", 32'(want.zero_error), 32'(result_out.zero_error));
                check_field("range_error", 32'(want.range_error),
                            32'(result_out.range_error));
                check_field("valid_res", 32'(want.valid_res), 32'(result_out.valid_res));
            end
        end
    end

    // The run ends as failed when neither channel moves a word for too long.
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((date_in.valid && date_in.ready) || (result_out.valid && result_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("gregorian_date_check_day_of_week regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        error_count = 0;
        full_rate   = 1'b0;
        rst_n                       <= 1'b0;
        date_in.valid               <= 1'b0;
        date_in.day_tens_char       <= CHAR_ZERO;
        date_in.day_units_char      <= CHAR_ZERO;
        date_in.month_tens_char     <= CHAR_ZERO;
        date_in.month_units_char    <= CHAR_ZERO;
        date_in.year_thousands_char <= CHAR_ZERO;
        date_in.year_hundreds_char  <= CHAR_ZERO;
        date_in.year_tens_char      <= CHAR_ZERO;
        date_in.year_units_char     <= CHAR_ZERO;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases first.
        foreach (DIRECTED_CASES[i])
            send_date(date_word_t'(DIRECTED_CASES[i].chars), DIRECTED_CASES[i].typed,
                      DIRECTED_CASES[i].want);
        drain_results();

        // Random phase. Every fourth stretch of fifty words runs at full rate,
        // and halfway through the sender waits for the pipeline to empty.
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            full_rate = ((n / 50) % 4) == 3;
            if (n == NUM_RANDOM / 2)
                drain_results();
            send_date(random_date(), 1'b0, RES_NONE);
        end
        full_rate = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("gregorian_date_check_day_of_week regression: pass");
        else
            $display("gregorian_date_check_day_of_week regression: fail");
        $finish;
    end

endmodule

>>> sim.f
src/gdc_pkg.sv
src/gdc_in_if.sv
src/gdc_out_if.sv
src/gdc_parse.sv
src/gdc_check.sv
src/gdc_weekday.sv
src/gregorian_date_check_day_of_week.sv
src/gdc_checker.sv
verif/tb_gregorian_date_check_day_of_week.sv
